>>> rtl/fmk_pkg.sv
// shared constants, action codes and character coding for the fm-index table builder
// no dependencies
package fmk_pkg;

  localparam int KMER_LEN_DEF    = 4;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int SAMPLE_DIST_DEF = 100;
  localparam int CHARS_GIVEN     = 4;
  localparam int DIGIT_BASE      = 5;
  localparam int MAX_KMER        = 6;

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 3;
  localparam int QCODE_W = 10;
  localparam int VALUE_W = 9;

  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_READ_OFS = 2'd1;
  localparam logic [1:0] ACT_READ_SMP = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;

  typedef logic [CHARS_GIVEN-1:0][CHAR_W-1:0] char_group_t;

  function automatic int code_space(int k);
    int v;
    v = 1;
    for (int i = 0; i < MAX_KMER; i++) begin
      if (i < k) v = v * DIGIT_BASE;
    end
    return v;
  endfunction

  function automatic logic [DIGIT_W-1:0] base5_digit(logic [CHAR_W-1:0] ch);
    logic [DIGIT_W-1:0] d;
    case (ch)
      CH_A:    d = 3'd1;
      CH_C:    d = 3'd2;
      CH_G:    d = 3'd3;
      CH_T:    d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/fm_index_kmer_table_builder_unit.sv
// fm-index table builder: first-row offsets, running counts and count snapshots
// depends on fmk_pkg and fmk_encoder
// add row and reads go through S_ROW or S_READ, which registers the result; clear
//   and rejected requests give done from S_IDLE; start is only taken while busy is low
// a snapshot row keeps busy high through the count memory sweep (S_SNAP, S_SNAP_END)
// reset and clear sweep the first-row and count tables, one entry a cycle, busy high
// results are strobed by done for one cycle; the receiver cannot stall
module fm_index_kmer_table_builder_unit #(
  parameter int KMER_LEN    = fmk_pkg::KMER_LEN_DEF,
  parameter int MAX_ROWS    = fmk_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_DIST = fmk_pkg::SAMPLE_DIST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [7:0]                    front_char0,
  input  logic [7:0]                    front_char1,
  input  logic [7:0]                    front_char2,
  input  logic [7:0]                    front_char3,
  input  logic [7:0]                    back_char0,
  input  logic [7:0]                    back_char1,
  input  logic [7:0]                    back_char2,
  input  logic [7:0]                    back_char3,
  input  logic [fmk_pkg::QCODE_W-1:0]   query_code,
  input  logic [1:0]                    query_sample,
  output logic                          done,
  output logic [fmk_pkg::QCODE_W-1:0]   last_code,
  output logic                          was_sampled,
  output logic [fmk_pkg::VALUE_W-1:0]   read_value,
  output logic                          error
);
  import fmk_pkg::*;

  localparam int CS          = code_space(KMER_LEN);
  localparam int CW          = $clog2(CS);
  localparam int CIW         = $clog2(CS + 1);
  localparam int RW          = $clog2(MAX_ROWS + 1);
  localparam int MAX_SAMPLES = (MAX_ROWS - 1) / SAMPLE_DIST + 1;
  localparam int TW          = $clog2(MAX_SAMPLES + 1);
  localparam int SD          = MAX_SAMPLES * CS;
  localparam int SAW         = $clog2(SD);
  localparam int PW          = $clog2(SAMPLE_DIST + 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ROW      = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_SNAP     = 3'd4;
  localparam logic [2:0] S_SNAP_END = 3'd5;

  logic [2:0]     state;
  logic [CIW-1:0] idx;
  logic [RW-1:0]  row_counter;
  logic [PW-1:0]  phase;
  logic [TW-1:0]  taken;
  logic [CW-1:0]  fcode;
  logic [CW-1:0]  lcode;
  logic [1:0]     act;
  logic           q_oor;
  logic [SAW-1:0] snap_base;
  logic           snap_v;
  logic [CW-1:0]  snap_a;

  logic [CW-1:0]  fc;
  logic [CW-1:0]  lc;
  logic [CW-1:0]  qidx;
  logic           q_in_range;
  logic           take_snap;

  logic [RW-1:0]      frt_mem [CS];
  logic [VALUE_W-1:0] cnt_mem [CS];
  logic [VALUE_W-1:0] smp_mem [SD];

  logic               frt_we;
  logic [CW-1:0]      frt_waddr;
  logic [RW-1:0]      frt_wdata;
  logic [CW-1:0]      frt_raddr;
  logic [RW-1:0]      frt_rdata;
  logic               cnt_we;
  logic [CW-1:0]      cnt_waddr;
  logic [VALUE_W-1:0] cnt_wdata;
  logic [CW-1:0]      cnt_raddr;
  logic [VALUE_W-1:0] cnt_rdata;
  logic               smp_we;
  logic [SAW-1:0]     smp_waddr;
  logic [SAW-1:0]     smp_raddr;
  logic [VALUE_W-1:0] smp_rdata;

  fmk_encoder #(
    .KMER_LEN(KMER_LEN),
    .CW      (CW)
  ) u_enc (
    .front     ({front_char3, front_char2, front_char1, front_char0}),
    .back      ({back_char3, back_char2, back_char1, back_char0}),
    .front_code(fc),
    .back_code (lc)
  );

  assign busy       = (state != S_IDLE);
  assign qidx       = CW'(query_code);
  assign q_in_range = (32'(query_code) < CS);
  assign take_snap  = (phase == PW'(0)) && (32'(taken) < MAX_SAMPLES);

  // memory ports
  always_comb begin
    frt_raddr = (action == ACT_ADD) ? fc : qidx;
    cnt_raddr = (state == S_SNAP) ? idx[CW-1:0] : lc;
    smp_raddr = SAW'(SAW'(query_sample) * SAW'(CS)) + SAW'(qidx);

    frt_we    = (state == S_CLEAR) || ((state == S_ROW) && (frt_rdata == '0));
    frt_waddr = (state == S_CLEAR) ? idx[CW-1:0] : fcode;
    frt_wdata = (state == S_CLEAR) ? '0 : RW'(row_counter + RW'(1));

    cnt_we    = (state == S_CLEAR) || (state == S_ROW);
    cnt_waddr = (state == S_CLEAR) ? idx[CW-1:0] : lcode;
    cnt_wdata = (state == S_CLEAR) ? '0 : VALUE_W'(cnt_rdata + VALUE_W'(1));

    smp_we    = snap_v;
    smp_waddr = snap_base + SAW'(snap_a);
  end

  always_ff @(posedge clk) begin
    if (frt_we) frt_mem[frt_waddr] <= frt_wdata;
    frt_rdata <= frt_mem[frt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_waddr] <= cnt_rdata;
    smp_rdata <= smp_mem[smp_raddr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      row_counter <= '0;
      phase       <= '0;
      taken       <= '0;
      done        <= 1'b0;
      snap_v      <= 1'b0;
    end else begin
      done   <= 1'b0;
      snap_v <= 1'b0;
      case (state)
        S_CLEAR: begin
          idx <= idx + CIW'(1);
          if (idx == CIW'(CS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act         <= action;
            fcode       <= fc;
            lcode       <= lc;
            q_oor       <= !q_in_range;
            last_code   <= '0;
            was_sampled <= 1'b0;
            read_value  <= '0;
            error       <= 1'b0;
            case (action)
              ACT_ADD: begin
                if (row_counter == RW'(MAX_ROWS)) begin
                  done  <= 1'b1;
                  error <= 1'b1;
                end else begin
                  state <= S_ROW;
                end
              end
              ACT_READ_OFS: state <= S_READ;
              ACT_READ_SMP: begin
                if (32'(query_sample) >= 32'(taken)) begin
                  done  <= 1'b1;
                  error <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                done        <= 1'b1;
                row_counter <= '0;
                phase       <= '0;
                taken       <= '0;
                idx         <= '0;
                state       <= S_CLEAR;
              end
            endcase
          end
        end
        S_ROW: begin
          done        <= 1'b1;
          last_code   <= QCODE_W'(lcode);
          was_sampled <= take_snap;
          read_value  <= '0;
          error       <= 1'b0;
          row_counter <= row_counter + RW'(1);
          phase       <= (phase == PW'(SAMPLE_DIST - 1)) ? '0 : phase + PW'(1);
          if (take_snap) begin
            taken     <= taken + TW'(1);
            snap_base <= SAW'(SAW'(taken) * SAW'(CS));
            idx       <= '0;
            state     <= S_SNAP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          done        <= 1'b1;
          last_code   <= '0;
          was_sampled <= 1'b0;
          error       <= 1'b0;
          if (q_oor) begin
            read_value <= '0;
          end else if (act == ACT_READ_OFS) begin
            read_value <= VALUE_W'(frt_rdata);
          end else begin
            read_value <= smp_rdata;
          end
          state <= S_IDLE;
        end
        S_SNAP: begin
          snap_v <= 1'b1;
          snap_a <= idx[CW-1:0];
          idx    <= idx + CIW'(1);
          if (idx == CIW'(CS - 1)) state <= S_SNAP_END;
        end
        S_SNAP_END: begin
          idx   <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_sample_on_error: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_sampled && error))
    else $error("snapshot flagged on a rejected request");

  a_clear_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_CLEAR) |=> (busy && done))
    else $error("clear did not start the sweep");

  a_row_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW) |=> (done && !error))
    else $error("row update without result");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (last_code == '0 && read_value == '0))
    else $error("error result carries data");
`endif

endmodule

>>> rtl/fmk_encoder.sv
// base-5 coding of the front and back character groups of one rotation
// depends on fmk_pkg
module fmk_encoder #(
  parameter int KMER_LEN = fmk_pkg::KMER_LEN_DEF,
  parameter int CW       = 10
) (
  input  fmk_pkg::char_group_t front,
  input  fmk_pkg::char_group_t back,
  output logic [CW-1:0]        front_code,
  output logic [CW-1:0]        back_code
);
  import fmk_pkg::*;

  always_comb begin
    logic [CW-1:0] fv;
    logic [CW-1:0] bv;
    int pos;
    fv = '0;
    bv = '0;
    for (int k = 0; k < KMER_LEN; k++) begin
      pos = CHARS_GIVEN - KMER_LEN + k;
      fv = CW'(fv * CW'(DIGIT_BASE));
      bv = CW'(bv * CW'(DIGIT_BASE));
      if (k < CHARS_GIVEN) fv = fv + CW'(base5_digit(front[k]));
      if (pos >= 0) bv = bv + CW'(base5_digit(back[pos]));
    end
    front_code = fv;
    back_code  = bv;
  end

endmodule
